// File: hw/rtl/mlfe_pkg.sv
// Shared types and constants of the monochrome framebuffer engine.
// Holds display geometry, LCD frame codes, the controller state type and
// the command and status structs between controller and datapath.
package mlfe_pkg;

    localparam int DISP_W      = 128;
    localparam int DISP_H      = 64;
    localparam int ROW_BYTES   = DISP_W / 8;
    localparam int STORE_BYTES = ROW_BYTES * DISP_H;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(ROW_BYTES);
    localparam int ROW_W       = $clog2(DISP_H);
    localparam int XPOS_W      = $clog2(DISP_W);
    localparam int HALF_W      = ROW_W - 1;

    localparam logic signed [11:0] X_LIMIT = 12'(DISP_W);
    localparam logic signed [11:0] Y_LIMIT = 12'(DISP_H);

    localparam logic [7:0] SYNC_CMD     = 8'hF8;
    localparam logic [7:0] SYNC_DATA    = 8'hFA;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    localparam logic [2:0] INIT_LAST_IDX = 3'd6;

    typedef enum logic [1:0] {
        FUNC_DRAW    = 2'd0,
        FUNC_FILL    = 2'd1,
        FUNC_REFRESH = 2'd2,
        FUNC_INIT    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_REF_HDR,
        ST_REF_DATA,
        ST_INIT
    } t_state;

    typedef enum logic [1:0] {
        OSRC_ROW_ADDR,
        OSRC_COL_ADDR,
        OSRC_DATA,
        OSRC_INIT
    } t_osrc;

    typedef struct packed {
        logic  capture;
        logic  setup;
        logic  clr_step;
        logic  fill_rd;
        logic  fill_wr;
        logic  fill_next;
        logic  ref_rd;
        logic  out_load;
        t_osrc out_src;
        logic  out_release;
        logic  out_last;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  clr_done;
        logic  fill_empty;
        logic  fill_done;
        logic  ref_ok;
        logic  out_free;
        logic  hdr_last;
        logic  init_last;
        logic  data_last;
    } t_dp_sts;

    // Mode command sequence sent by the init operation.
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h30;
            3'd1:    v = 8'h30;
            3'd2:    v = 8'h01;
            3'd3:    v = 8'h06;
            3'd4:    v = 8'h0C;
            3'd5:    v = 8'h34;
            3'd6:    v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/mono_lcd_framebuffer_engine_unit.sv
// Top level of the monochrome framebuffer engine with serial LCD framing.
// Depends on mlfe_pkg, mlfe_ctrl and mlfe_dpath (which uses mlfe_ram).
//
// The block holds a 128x64 one-bit framebuffer (1024 bytes, MSB first) and
// takes one operation per input beat: draw pixel, fill, refresh a row pair
// or send the init commands. After reset a clearing pass writes zeros to the
// store, one byte a cycle, with s_axis_tready held low. A pixel draw or a
// fill reads and then rewrites each touched byte in turn, a read-modify-write
// through the single store write port. A refresh with pos_y in 0 to 31 gives
// 34 beats at one beat a cycle while the sink is ready; init gives 7 beats.
// Both are paced by the one-beat output register, which lets the next item
// be accepted while the final beat still waits to be taken.
module mono_lcd_framebuffer_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x[10:0], pos_y[21:11], rect_w[31:22], rect_h[41:32],
    // clip_on[42], color_on[43], zero[47:44]
    input  logic [47:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sync_byte[7:0], high_part[15:8], low_part[23:16]
    output logic [23:0] m_axis_tdata,
    // is_command[0], release_select[1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import mlfe_pkg::*;

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic [7:0] out_byte;
    logic       out_cmd;
    logic       out_release;

    mlfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mlfe_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (s_axis_tuser),
        .i_pos_x       (s_axis_tdata[10:0]),
        .i_pos_y       (s_axis_tdata[21:11]),
        .i_rect_w      (s_axis_tdata[31:22]),
        .i_rect_h      (s_axis_tdata[41:32]),
        .i_clip_on     (s_axis_tdata[42]),
        .i_color_on    (s_axis_tdata[43]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_byte    (out_byte),
        .o_out_cmd     (out_cmd),
        .o_out_release (out_release),
        .o_out_last    (m_axis_tlast)
    );

    // Each payload byte goes out as its high nibble and its low nibble moved up.
    assign m_axis_tdata = {out_byte[3:0], 4'h0, out_byte[7:4], 4'h0,
                           (out_cmd ? SYNC_CMD : SYNC_DATA)};
    assign m_axis_tuser = {out_release, out_cmd};

endmodule

// File: hw/rtl/mlfe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module mlfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mlfe_ctrl.sv
// Controller of the framebuffer engine: sequences clearing, fills, refresh
// and init through commands to the datapath. Depends on mlfe_pkg.
module mlfe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mlfe_pkg::t_dp_sts i_sts,
    output mlfe_pkg::t_dp_cmd o_cmd
);
    import mlfe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                unique case (i_sts.func)
                    FUNC_DRAW, FUNC_FILL: begin
                        n_state = i_sts.fill_empty ? ST_IDLE : ST_FILL_RD;
                    end
                    FUNC_REFRESH: begin
                        n_state = i_sts.ref_ok ? ST_REF_HDR : ST_IDLE;
                    end
                    FUNC_INIT: begin
                        n_state = ST_INIT;
                    end
                endcase
            end
            ST_FILL_RD: begin
                n_state = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                n_state = i_sts.fill_done ? ST_IDLE : ST_FILL_RD;
            end
            ST_REF_HDR: begin
                if (i_sts.out_free && i_sts.hdr_last) n_state = ST_REF_DATA;
            end
            ST_REF_DATA: begin
                if (i_sts.out_free && i_sts.data_last) n_state = ST_IDLE;
            end
            ST_INIT: begin
                if (i_sts.out_free && i_sts.init_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            ST_FILL_RD: begin
                o_cmd.fill_rd = 1'b1;
            end
            ST_FILL_WR: begin
                o_cmd.fill_wr   = 1'b1;
                o_cmd.fill_next = !i_sts.fill_done;
            end
            ST_REF_HDR: begin
                o_cmd.out_load    = i_sts.out_free;
                o_cmd.out_src     = i_sts.hdr_last ? OSRC_COL_ADDR : OSRC_ROW_ADDR;
                o_cmd.out_release = 1'b1;
                // The first store read goes out together with the second command.
                o_cmd.ref_rd      = i_sts.out_free && i_sts.hdr_last;
            end
            ST_REF_DATA: begin
                o_cmd.out_load    = i_sts.out_free;
                o_cmd.out_src     = OSRC_DATA;
                o_cmd.out_release = i_sts.data_last;
                o_cmd.out_last    = i_sts.data_last;
                o_cmd.ref_rd      = i_sts.out_free && !i_sts.data_last;
            end
            ST_INIT: begin
                o_cmd.out_load    = i_sts.out_free;
                o_cmd.out_src     = OSRC_INIT;
                o_cmd.out_release = 1'b1;
                o_cmd.out_last    = i_sts.init_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/mlfe_dpath.sv
// Datapath of the framebuffer engine: operand registers, clip arithmetic,
// store addressing, read-modify-write masks and the output frame register.
// Depends on mlfe_pkg and mlfe_ram.
module mlfe_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mlfe_pkg::t_dp_cmd  i_cmd,
    output mlfe_pkg::t_dp_sts  o_sts,
    input  logic [1:0]         i_func,
    input  logic signed [10:0] i_pos_x,
    input  logic signed [10:0] i_pos_y,
    input  logic [9:0]         i_rect_w,
    input  logic [9:0]         i_rect_h,
    input  logic               i_clip_on,
    input  logic               i_color_on,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_out_cmd,
    output logic               o_out_release,
    output logic               o_out_last
);
    import mlfe_pkg::*;

    // Operands of the current item.
    t_func              r_func;
    logic signed [10:0] r_px;
    logic signed [10:0] r_py;
    logic [9:0]         r_rw;
    logic [9:0]         r_rh;
    logic               r_clip;
    logic               r_color;

    // Fill bounds and walk position.
    logic [XPOS_W-1:0]  r_x0;
    logic [XPOS_W-1:0]  r_x1m;
    logic [ROW_W-1:0]   r_y1m;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;

    // Sequencing counters.
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [2:0]         r_idx;
    logic [COL_W+1:0]   r_kidx;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_cmd;
    logic               r_out_release;
    logic               r_out_last;

    logic               is_draw;
    logic               clip_eff;
    logic [9:0]         ext_w;
    logic [9:0]         ext_h;
    logic signed [11:0] x_beg;
    logic signed [11:0] x_end;
    logic signed [11:0] y_beg;
    logic signed [11:0] y_end;
    logic signed [11:0] x_lo;
    logic signed [11:0] x_hi;
    logic signed [11:0] y_lo;
    logic signed [11:0] y_hi;
    logic signed [11:0] x_hi_m;
    logic signed [11:0] y_hi_m;

    logic [COL_W-1:0]   col_beg;
    logic [COL_W-1:0]   col_end;
    logic [7:0]         lmask;
    logic [7:0]         rmask;
    logic [7:0]         mask;
    logic [7:0]         rdata;
    logic [7:0]         fill_wdata;
    logic [ADDR_W-1:0]  fill_addr;
    logic [ADDR_W-1:0]  ref_addr;
    logic [7:0]         load_byte;
    logic               out_free;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;

    // A pixel draw is a fill of a clipped one-by-one rectangle.
    assign is_draw  = (r_func == FUNC_DRAW);
    assign clip_eff = is_draw | r_clip;
    assign ext_w    = is_draw ? 10'd1 : r_rw;
    assign ext_h    = is_draw ? 10'd1 : r_rh;
    assign x_beg    = {r_px[10], r_px};
    assign y_beg    = {r_py[10], r_py};
    assign x_end    = x_beg + $signed({2'b00, ext_w});
    assign y_end    = y_beg + $signed({2'b00, ext_h});
    assign x_lo     = (clip_eff && x_beg > 12'sd0) ? x_beg : 12'sd0;
    assign y_lo     = (clip_eff && y_beg > 12'sd0) ? y_beg : 12'sd0;
    assign x_hi     = (clip_eff && x_end < X_LIMIT) ? x_end : X_LIMIT;
    assign y_hi     = (clip_eff && y_end < Y_LIMIT) ? y_end : Y_LIMIT;
    assign x_hi_m   = x_hi - 12'sd1;
    assign y_hi_m   = y_hi - 12'sd1;

    assign col_beg    = r_x0[XPOS_W-1:3];
    assign col_end    = r_x1m[XPOS_W-1:3];
    assign lmask      = (r_col == col_beg) ? (8'hFF >> r_x0[2:0]) : 8'hFF;
    assign rmask      = (r_col == col_end) ? (8'hFF << (3'd7 - r_x1m[2:0])) : 8'hFF;
    assign mask       = lmask & rmask;
    assign fill_wdata = r_color ? (rdata | mask) : (rdata & ~mask);
    assign fill_addr  = {r_row, r_col};
    // Data byte k of a refresh: rows j and j + 32 share the low row bits.
    assign ref_addr   = {r_kidx[COL_W], r_py[HALF_W-1:0], r_kidx[COL_W-1:0]};

    assign ram_we    = i_cmd.clr_step | i_cmd.fill_wr;
    assign ram_waddr = i_cmd.clr_step ? r_clr_addr : fill_addr;
    assign ram_wdata = i_cmd.clr_step ? 8'h00 : fill_wdata;
    assign ram_re    = i_cmd.fill_rd | i_cmd.ref_rd;
    assign ram_raddr = i_cmd.fill_rd ? fill_addr : ref_addr;

    mlfe_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        unique case (i_cmd.out_src)
            OSRC_ROW_ADDR: load_byte = CMD_SET_ADDR | {3'b000, r_py[HALF_W-1:0]};
            OSRC_COL_ADDR: load_byte = CMD_SET_ADDR;
            OSRC_DATA:     load_byte = rdata;
            OSRC_INIT:     load_byte = init_byte(r_idx);
            default:       load_byte = 8'h00;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= t_func'(i_func);
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_rw    <= i_rect_w;
            r_rh    <= i_rect_h;
            r_clip  <= i_clip_on;
            r_color <= i_color_on;
        end
        if (i_cmd.setup) begin
            r_x0  <= x_lo[XPOS_W-1:0];
            r_x1m <= x_hi_m[XPOS_W-1:0];
            r_y1m <= y_hi_m[ROW_W-1:0];
            r_row <= y_lo[ROW_W-1:0];
            r_col <= x_lo[XPOS_W-1:3];
        end else if (i_cmd.fill_next) begin
            if (r_col == col_end) begin
                r_col <= col_beg;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_out_byte    <= load_byte;
            r_out_cmd     <= (i_cmd.out_src != OSRC_DATA);
            r_out_release <= i_cmd.out_release;
            r_out_last    <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_idx       <= '0;
            r_kidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.setup) begin
                r_idx <= '0;
            end else if (i_cmd.out_load && i_cmd.out_src != OSRC_DATA) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_cmd.setup) begin
                r_kidx <= '0;
            end else if (i_cmd.ref_rd) begin
                r_kidx <= r_kidx + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.func       = r_func;
    assign o_sts.clr_done   = &r_clr_addr;
    assign o_sts.fill_empty = (x_hi <= x_lo) || (y_hi <= y_lo);
    assign o_sts.fill_done  = (r_row == r_y1m) && (r_col == col_end);
    assign o_sts.ref_ok     = !r_py[10] && (r_py[9:HALF_W] == '0);
    assign o_sts.out_free   = out_free;
    assign o_sts.hdr_last   = r_idx[0];
    assign o_sts.init_last  = (r_idx == INIT_LAST_IDX);
    // All 32 bytes have been read once the counter reaches 32.
    assign o_sts.data_last  = r_kidx[COL_W+1];

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_cmd     = r_out_cmd;
    assign o_out_release = r_out_release;
    assign o_out_last    = r_out_last;

endmodule

// File: hw/rtl/mlfe_checker.sv
// Port-level checker for the framebuffer engine, bound to the top level.
// Depends on mlfe_pkg for the LCD frame codes.
module mlfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import mlfe_pkg::*;

    // A stalled output beat keeps its whole content.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // The sync byte has to agree with the command flag.
    a_sync_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] ? (m_axis_tdata[7:0] == SYNC_CMD)
                                           : (m_axis_tdata[7:0] == SYNC_DATA)))
        else $error("sync byte does not match frame kind");

    // Select is released after every command and after the final data beat only.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1] == (m_axis_tuser[0] || m_axis_tlast)))
        else $error("release flag inconsistent with frame kind");

    // Both nibble bytes carry zeros in their low halves.
    a_nibbles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:8] == 4'h0) && (m_axis_tdata[19:16] == 4'h0))
        else $error("nibble byte has low bits set");

    // An accepted item makes the block drop s_axis_tready, so no two items are taken back to back.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind mono_lcd_framebuffer_engine_unit mlfe_checker u_mlfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
